[sv/sktab_pkg.sv]
// Package for the sorted key table: command and status codes, cell control type.
`default_nettype none
package sktab_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage
`default_nettype wire

[sv/sktab_cell.sv]
// One table cell: holds a key, compares it with the probe key, shifts with its neighbors.
`default_nettype none
module sktab_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_valid,
    input  wire logic signed [sktab_pkg::KEY_W-1:0] i_probe,
    input  wire logic signed [sktab_pkg::KEY_W-1:0] i_left_key,
    input  wire logic signed [sktab_pkg::KEY_W-1:0] i_right_key,
    input  wire logic                              i_left_lt,
    input  wire sktab_pkg::t_cell_ctl              i_ctl,
    output logic signed [sktab_pkg::KEY_W-1:0]      o_key,
    output logic                                   o_lt,
    output logic                                   o_eq
);
    import sktab_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    assign o_lt  = i_valid && (r_key < i_probe);
    assign o_eq  = i_valid && (r_key == i_probe);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins) begin
            // cells above the insert point take the left neighbor, the boundary takes the probe
            if (!i_left_lt) begin
                n_key = i_left_key;
            end else if (!o_lt) begin
                n_key = i_probe;
            end
        end else if (i_ctl.del) begin
            if (!o_lt) begin
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
`default_nettype wire

[sv/sktab_enc.sv]
// Thermometer-to-count encoder: number of leading ones in the less-than flags.
`default_nettype none
module sktab_enc #(
    parameter int CAPACITY = 32,
    parameter int CW       = 6
) (
    input  wire logic [CAPACITY-1:0] i_therm,
    output logic      [CW-1:0]       o_count
);

    logic [CAPACITY:0] w_ext;

    assign w_ext = {1'b0, i_therm};

    always_comb begin
        o_count = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_ext[i] && !w_ext[i+1]) begin
                o_count = o_count | CW'(i + 1);
            end
        end
    end

endmodule
`default_nettype wire

[sv/sorted_key_table.sv]
// Top level of the sorted key table: command register, cell chain and result register.
// Keeps up to CAPACITY distinct signed keys in ascending order, one key per cell of a
// shifting cell chain. A command goes into the command register, then executes once no
// earlier result is held untaken: every cell compares its key with the command key and,
// for an insert or delete, shifts its key in from a neighbor. The result (status, position,
// fill) is registered and held until taken; the next command is accepted once the current
// one has written its result. The execute path is each cell's key compare plus the position
// encoder and match OR across the chain. No clearing pass: reset empties the table.
`default_nettype none
module sorted_key_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [1:0]                        i_cmd,
    input  wire logic signed [sktab_pkg::KEY_W-1:0] i_key,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [1:0]                             o_status,
    output logic [4:0]                             o_position,
    output logic [5:0]                             o_fill
);
    import sktab_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                    r_busy;
    logic                    r_ovalid;
    t_cmd                    r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    t_status                 r_status;
    t_status                 n_status;
    logic [CW-1:0]           r_pos;
    logic [CW-1:0]           n_pos;

    logic signed [KEY_W-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic [CW-1:0]           w_at;
    logic                    w_exec;
    logic                    w_hit;
    logic                    w_full;
    t_cell_ctl               w_ctl;

    assign o_ready    = !r_busy;
    assign o_valid    = r_ovalid;
    assign o_status   = r_status;
    assign o_position = 5'(r_pos);
    assign o_fill     = 6'(r_count);

    assign w_exec = r_busy && (!r_ovalid || i_ready);
    assign w_hit  = |w_eq;
    assign w_full = (r_count == CW'(CAPACITY));

    always_comb begin
        w_ctl.ins = w_exec && (r_cmd == CMD_INSERT) && !w_hit && !w_full;
        w_ctl.del = w_exec && (r_cmd == CMD_DELETE) && w_hit;
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [KEY_W-1:0] w_left;
            logic signed [KEY_W-1:0] w_right;
            logic                    w_left_lt;
            if (g == 0) begin : g_first
                assign w_left    = r_key;
                assign w_left_lt = 1'b1;
            end else begin : g_mid
                assign w_left    = w_cell_key[g-1];
                assign w_left_lt = w_lt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_cell_key[g];
            end else begin : g_inner
                assign w_right = w_cell_key[g+1];
            end
            sktab_cell u_cell (
                .i_clk       (i_clk),
                .i_valid     (CW'(g) < r_count),
                .i_probe     (r_key),
                .i_left_key  (w_left),
                .i_right_key (w_right),
                .i_left_lt   (w_left_lt),
                .i_ctl       (w_ctl),
                .o_key       (w_cell_key[g]),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g])
            );
        end
    endgenerate

    sktab_enc #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_enc (
        .i_therm (w_lt),
        .o_count (w_at)
    );

    always_comb begin
        n_count  = r_count;
        n_status = ST_NOTFOUND;
        n_pos    = '0;
        case (r_cmd)
            CMD_INSERT: begin
                if (w_hit) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_pos    = w_at;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (w_hit) begin
                    n_status = ST_OK;
                    n_pos    = w_at;
                    n_count  = r_count - CW'(1);
                end
            end
            CMD_FIND: begin
                if (w_hit) begin
                    n_status = ST_OK;
                    n_pos    = w_at;
                end
            end
            default: begin
                n_status = ST_NOTFOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_valid && !r_busy) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_ovalid <= 1'b1;
                r_count  <= n_count;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !r_busy) begin
            r_cmd <= t_cmd'(i_cmd);
            r_key <= i_key;
        end
        if (w_exec) begin
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

endmodule
`default_nettype wire

[sv/sktab_chk.sv]
// Port-level checker for the sorted key table, bound to the top level.
`default_nettype none
module sktab_chk #(
    parameter int CAPACITY = 32
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_status,
    input wire logic [4:0] o_position,
    input wire logic [5:0] o_fill
);
    import sktab_pkg::*;

    // a failed command reports position zero
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_position == 5'd0))
        else $error("nonzero position on failed command");

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (CAPACITY < 64)) |-> (32'(o_fill) <= 32'(CAPACITY)))
        else $error("fill above capacity");

    // one command in flight: after a transfer in, input is blocked in the next cycle
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second command accepted while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_position)
                                   && $stable(o_fill)))
        else $error("stalled result changed");

endmodule

bind sorted_key_table sktab_chk #(
    .CAPACITY (CAPACITY)
) u_sktab_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_status   (o_status),
    .o_position (o_position),
    .o_fill     (o_fill)
);
`default_nettype wire
